FILE: hw/rtl/iss_pkg.sv
// Shared constants, codes and types of the interlocked setpoint stepper.
package iss_pkg;

  // DAC resolution default; the top level can override it.
  localparam int unsigned DacBitsDefault = 12;

  // Register field widths.
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CmdW    = 8;

  // APB register map: register i at byte address 4*i.
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] RegSamplePeriod = 3'd0;
  localparam logic [RegIdxW-1:0] RegMainLimit    = 3'd1;
  localparam logic [RegIdxW-1:0] RegThirdLimit   = 3'd2;
  localparam logic [RegIdxW-1:0] RegCoarseStep   = 3'd3;
  localparam logic [RegIdxW-1:0] RegFineStep     = 3'd4;
  localparam logic [RegIdxW-1:0] RegThirdStep    = 3'd5;

  // Register reset values.
  localparam logic [PeriodW-1:0] RstSamplePeriod = 16'd200;
  localparam logic [CfgW-1:0]    RstMainLimit    = 12'd3103;
  localparam logic [CfgW-1:0]    RstThirdLimit   = 12'd1861;
  localparam logic [CfgW-1:0]    RstCoarseStep   = 12'd31;
  localparam logic [CfgW-1:0]    RstFineStep     = 12'd3;
  localparam logic [CfgW-1:0]    RstThirdStep    = 12'd20;

  // Result status codes.
  localparam logic [StatusW-1:0] StUpdated    = 3'd0;
  localparam logic [StatusW-1:0] StNotReadyCh1 = 3'd1;
  localparam logic [StatusW-1:0] StNotReadyCh2 = 3'd2;
  localparam logic [StatusW-1:0] StInvalid    = 3'd3;
  localparam logic [StatusW-1:0] StTick       = 3'd4;
  localparam logic [StatusW-1:0] StTickSample = 3'd5;

  // Command characters.
  localparam logic [CmdW-1:0] CmdCh1DnCoarse = 8'h30; // '0'
  localparam logic [CmdW-1:0] CmdCh1UpCoarse = 8'h31; // '1'
  localparam logic [CmdW-1:0] CmdCh1DnFine   = 8'h32; // '2'
  localparam logic [CmdW-1:0] CmdCh1UpFine   = 8'h33; // '3'
  localparam logic [CmdW-1:0] CmdCh2UpCoarse = 8'h34; // '4'
  localparam logic [CmdW-1:0] CmdCh2DnCoarse = 8'h35; // '5'
  localparam logic [CmdW-1:0] CmdCh2UpFine   = 8'h36; // '6'
  localparam logic [CmdW-1:0] CmdCh2DnFine   = 8'h37; // '7'
  localparam logic [CmdW-1:0] CmdCh3Up       = 8'h38; // '8'
  localparam logic [CmdW-1:0] CmdCh3Dn       = 8'h39; // '9'

  // Item kind on the input tuser.
  localparam logic FuncCmd  = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef struct packed {
    logic [PeriodW-1:0] sample_period;
    logic [CfgW-1:0]    main_limit;
    logic [CfgW-1:0]    third_limit;
    logic [CfgW-1:0]    coarse_step;
    logic [CfgW-1:0]    fine_step;
    logic [CfgW-1:0]    third_step;
  } iss_cfg_t;

  // Interlock and tick timing state.
  typedef struct packed {
    logic               ready_one;
    logic               ready_two;
    logic [PeriodW-1:0] tick_count;
  } iss_ctrl_t;

endpackage

FILE: hw/rtl/iss_core.sv
// Combinational step logic: decode, tick timing, interlock and saturating steps.
module iss_core #(
  parameter int unsigned DAC_BITS = iss_pkg::DacBitsDefault
) (
  input  iss_pkg::iss_cfg_t              cfg_i,
  input  iss_pkg::iss_ctrl_t             ctrl_i,
  input  logic [DAC_BITS-1:0]            level_one_i,
  input  logic [DAC_BITS-1:0]            level_two_i,
  input  logic [DAC_BITS-1:0]            level_three_i,
  input  logic                           func_i,
  input  logic [iss_pkg::CmdW-1:0]       cmd_i,
  input  logic                           ok_one_i,
  input  logic                           ok_two_i,
  output iss_pkg::iss_ctrl_t             ctrl_o,
  output logic [DAC_BITS-1:0]            level_one_o,
  output logic [DAC_BITS-1:0]            level_two_o,
  output logic [DAC_BITS-1:0]            level_three_o,
  output logic [iss_pkg::StatusW-1:0]    status_o
);

  localparam int unsigned WideW = (DAC_BITS > iss_pkg::CfgW) ? DAC_BITS : iss_pkg::CfgW;
  localparam int unsigned SumW  = WideW + 1;
  localparam logic [SumW-1:0] DacMax = SumW'((1 << DAC_BITS) - 1);

  // min(level + step, clamped limit); result never exceeds the DAC range
  function automatic logic [DAC_BITS-1:0] step_up(logic [DAC_BITS-1:0] lvl,
                                                  logic [iss_pkg::CfgW-1:0] stp,
                                                  logic [iss_pkg::CfgW-1:0] lim);
    logic [SumW-1:0] lim_w;
    logic [SumW-1:0] sum;
    lim_w = SumW'(lim);
    if (lim_w > DacMax) lim_w = DacMax;
    sum = SumW'(lvl) + SumW'(stp);
    return (sum < lim_w) ? DAC_BITS'(sum) : DAC_BITS'(lim_w);
  endfunction

  // floor at zero
  function automatic logic [DAC_BITS-1:0] step_dn(logic [DAC_BITS-1:0] lvl,
                                                  logic [iss_pkg::CfgW-1:0] stp);
    logic [SumW-1:0] diff;
    diff = SumW'(lvl) - SumW'(stp);
    return (SumW'(lvl) >= SumW'(stp)) ? DAC_BITS'(diff) : '0;
  endfunction

  logic [iss_pkg::PeriodW:0] tick_next;
  logic                      is_ch1_cmd;
  logic                      is_ch23_cmd;

  assign tick_next   = {1'b0, ctrl_i.tick_count} + (iss_pkg::PeriodW + 1)'(1);
  assign is_ch1_cmd  = (cmd_i >= iss_pkg::CmdCh1DnCoarse) && (cmd_i <= iss_pkg::CmdCh1UpFine);
  assign is_ch23_cmd = (cmd_i >= iss_pkg::CmdCh2UpCoarse) && (cmd_i <= iss_pkg::CmdCh3Dn);

  always_comb begin
    ctrl_o        = ctrl_i;
    level_one_o   = level_one_i;
    level_two_o   = level_two_i;
    level_three_o = level_three_i;
    status_o      = iss_pkg::StInvalid;

    if (func_i == iss_pkg::FuncTick) begin
      if (tick_next >= {1'b0, cfg_i.sample_period}) begin
        ctrl_o.ready_one  = ok_one_i;
        ctrl_o.ready_two  = ok_two_i;
        ctrl_o.tick_count = '0;
        status_o          = iss_pkg::StTickSample;
      end else begin
        ctrl_o.tick_count = tick_next[iss_pkg::PeriodW-1:0];
        status_o          = iss_pkg::StTick;
      end
    end else if (is_ch1_cmd && !ctrl_i.ready_one) begin
      status_o = iss_pkg::StNotReadyCh1;
    end else if (is_ch23_cmd && !ctrl_i.ready_one) begin
      status_o = iss_pkg::StNotReadyCh1;
    end else if (is_ch23_cmd && !ctrl_i.ready_two) begin
      status_o = iss_pkg::StNotReadyCh2;
    end else if (is_ch1_cmd || is_ch23_cmd) begin
      status_o = iss_pkg::StUpdated;
      unique case (cmd_i)
        iss_pkg::CmdCh1DnCoarse: level_one_o = step_dn(level_one_i, cfg_i.coarse_step);
        iss_pkg::CmdCh1UpCoarse:
          level_one_o = step_up(level_one_i, cfg_i.coarse_step, cfg_i.main_limit);
        iss_pkg::CmdCh1DnFine:   level_one_o = step_dn(level_one_i, cfg_i.fine_step);
        iss_pkg::CmdCh1UpFine:
          level_one_o = step_up(level_one_i, cfg_i.fine_step, cfg_i.main_limit);
        iss_pkg::CmdCh2UpCoarse:
          level_two_o = step_up(level_two_i, cfg_i.coarse_step, cfg_i.main_limit);
        iss_pkg::CmdCh2DnCoarse: level_two_o = step_dn(level_two_i, cfg_i.coarse_step);
        iss_pkg::CmdCh2UpFine:
          level_two_o = step_up(level_two_i, cfg_i.fine_step, cfg_i.main_limit);
        iss_pkg::CmdCh2DnFine:   level_two_o = step_dn(level_two_i, cfg_i.fine_step);
        iss_pkg::CmdCh3Up:
          level_three_o = step_up(level_three_i, cfg_i.third_step, cfg_i.third_limit);
        iss_pkg::CmdCh3Dn:       level_three_o = step_dn(level_three_i, cfg_i.third_step);
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/interlocked_setpoint_stepper.sv
// Top level: stream ports, APB registers, input/output registers, setpoint state.
// An accepted input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while the output is not stalled; the step logic
// between the input and result registers is one decode plus one 13-bit add/compare.
// Reset (rst_ni low, async): setpoints, ready flags and tick count go to zero,
// registers take their defaults, both stream stages empty.
module interlocked_setpoint_stepper #(
  parameter int unsigned DAC_BITS = iss_pkg::DacBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // cmd_byte[7:0], temp_ok_one, temp_ok_two
  input  logic                          s_axis_tuser,  // func
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[2:0], enable_one, enable_two, enable_three,
  // setpoint_one, setpoint_two, setpoint_three (DAC_BITS each), zero fill
  output logic [((6 + 3*DAC_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iss_pkg::ApbAddrW-1:0]  paddr,
  input  logic [iss_pkg::ApbDataW-1:0]  pwdata,
  output logic [iss_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned OutPackW = 6 + 3 * DAC_BITS;
  localparam int unsigned OutW     = ((OutPackW + 7) / 8) * 8;

  // ---------------- configuration registers ----------------
  iss_pkg::iss_cfg_t              cfg_q;
  logic [iss_pkg::RegIdxW-1:0]    reg_idx;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[iss_pkg::ApbAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period <= iss_pkg::RstSamplePeriod;
      cfg_q.main_limit    <= iss_pkg::RstMainLimit;
      cfg_q.third_limit   <= iss_pkg::RstThirdLimit;
      cfg_q.coarse_step   <= iss_pkg::RstCoarseStep;
      cfg_q.fine_step     <= iss_pkg::RstFineStep;
      cfg_q.third_step    <= iss_pkg::RstThirdStep;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        iss_pkg::RegSamplePeriod: cfg_q.sample_period <= pwdata[iss_pkg::PeriodW-1:0];
        iss_pkg::RegMainLimit:    cfg_q.main_limit    <= pwdata[iss_pkg::CfgW-1:0];
        iss_pkg::RegThirdLimit:   cfg_q.third_limit   <= pwdata[iss_pkg::CfgW-1:0];
        iss_pkg::RegCoarseStep:   cfg_q.coarse_step   <= pwdata[iss_pkg::CfgW-1:0];
        iss_pkg::RegFineStep:     cfg_q.fine_step     <= pwdata[iss_pkg::CfgW-1:0];
        iss_pkg::RegThirdStep:    cfg_q.third_step    <= pwdata[iss_pkg::CfgW-1:0];
        default: ; // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      iss_pkg::RegSamplePeriod: prdata = iss_pkg::ApbDataW'(cfg_q.sample_period);
      iss_pkg::RegMainLimit:    prdata = iss_pkg::ApbDataW'(cfg_q.main_limit);
      iss_pkg::RegThirdLimit:   prdata = iss_pkg::ApbDataW'(cfg_q.third_limit);
      iss_pkg::RegCoarseStep:   prdata = iss_pkg::ApbDataW'(cfg_q.coarse_step);
      iss_pkg::RegFineStep:     prdata = iss_pkg::ApbDataW'(cfg_q.fine_step);
      iss_pkg::RegThirdStep:    prdata = iss_pkg::ApbDataW'(cfg_q.third_step);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // The result register advances when it is empty or being drained; the input register
  // refills whenever its beat moves on, so beats flow every cycle unless the output stalls.
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic s_fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance)       out_valid_q <= in_valid_q;
    end
  end

  // ---------------- input register ----------------
  logic                     func_q;
  logic [iss_pkg::CmdW-1:0] cmd_q;
  logic                     ok_one_q;
  logic                     ok_two_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      func_q   <= s_axis_tuser;
      cmd_q    <= s_axis_tdata[7:0];
      ok_one_q <= s_axis_tdata[8];
      ok_two_q <= s_axis_tdata[9];
    end
  end

  // ---------------- architectural state ----------------
  iss_pkg::iss_ctrl_t     ctrl_q, ctrl_d;
  logic [DAC_BITS-1:0]    level_one_q, level_one_d;
  logic [DAC_BITS-1:0]    level_two_q, level_two_d;
  logic [DAC_BITS-1:0]    level_three_q, level_three_d;
  logic [iss_pkg::StatusW-1:0] status_d;
  logic                   step_en;

  // state commits in the same cycle the beat enters the result register
  assign step_en = in_valid_q && advance;

  iss_core #(
    .DAC_BITS(DAC_BITS)
  ) u_core (
    .cfg_i        (cfg_q),
    .ctrl_i       (ctrl_q),
    .level_one_i  (level_one_q),
    .level_two_i  (level_two_q),
    .level_three_i(level_three_q),
    .func_i       (func_q),
    .cmd_i        (cmd_q),
    .ok_one_i     (ok_one_q),
    .ok_two_i     (ok_two_q),
    .ctrl_o       (ctrl_d),
    .level_one_o  (level_one_d),
    .level_two_o  (level_two_d),
    .level_three_o(level_three_d),
    .status_o     (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q        <= '0;
      level_one_q   <= '0;
      level_two_q   <= '0;
      level_three_q <= '0;
    end else if (step_en) begin
      ctrl_q        <= ctrl_d;
      level_one_q   <= level_one_d;
      level_two_q   <= level_two_d;
      level_three_q <= level_three_d;
    end
  end

  // ---------------- result register ----------------
  logic [OutPackW-1:0] out_pack_d;
  logic [OutPackW-1:0] out_pack_q;

  // enable chain: ch3 is always ready, so it follows ch2
  assign out_pack_d = {level_three_d, level_two_d, level_one_d,
                       ctrl_d.ready_one && ctrl_d.ready_two,
                       ctrl_d.ready_one && ctrl_d.ready_two,
                       ctrl_d.ready_one,
                       status_d};

  always_ff @(posedge clk_i) begin
    if (step_en) out_pack_q <= out_pack_d;
  end

  assign m_axis_tdata = OutW'(out_pack_q);

endmodule

FILE: hw/rtl/iss_checker.sv
// Port-level checker for the setpoint stepper and its bind.
module iss_checker #(
  parameter int unsigned DAC_BITS = iss_pkg::DacBitsDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [((6 + 3*DAC_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  logic [iss_pkg::StatusW-1:0] status;
  logic                        en_one;
  logic                        en_two;
  logic                        en_three;

  assign status   = m_axis_tdata[2:0];
  assign en_one   = m_axis_tdata[3];
  assign en_two   = m_axis_tdata[4];
  assign en_three = m_axis_tdata[5];

  // a stalled output beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // interlock chain
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!en_two || en_one) && (en_three == en_two))
    else $error("enable chain broken");

  // refusal codes agree with the enables they report
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (status != iss_pkg::StNotReadyCh1 || !en_one) &&
      (status != iss_pkg::StNotReadyCh2 || (en_one && !en_two)) &&
      (status != iss_pkg::StUpdated || en_one))
    else $error("status disagrees with enables");

  // a backed-up output that is not drained leaves room for at most one beat
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready
      |=> !(m_axis_tvalid && !m_axis_tready) || !s_axis_tready)
    else $error("input accepted with both stages full");

endmodule

bind interlocked_setpoint_stepper iss_checker #(
  .DAC_BITS(DAC_BITS)
) u_iss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
